FILE: hw/rtl/integer_to_word_tokens_assert.svh
// Assertion macros for the word token block.
`ifndef INTEGER_TO_WORD_TOKENS_ASSERT_SVH
`define INTEGER_TO_WORD_TOKENS_ASSERT_SVH
`ifndef SYNTHESIS
`define ITW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ITW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next cycle check failed");
`else
`define ITW_ASSERT_IMP(lbl, ante, cons)
`define ITW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/itw_pkg.sv
package itw_pkg;

	localparam int VALUE_W = 31;
	localparam int WORD_W  = 5;
	localparam int DIGITS  = 10;
	localparam int CNT_W   = $clog2(VALUE_W);

	localparam logic [WORD_W-1:0] TOK_ZERO       = 5'd0;
	localparam logic [WORD_W-1:0] TOK_TEENS_BASE = 5'd10;
	localparam logic [WORD_W-1:0] TOK_TENS_BASE  = 5'd18;
	localparam logic [WORD_W-1:0] TOK_HUNDRED    = 5'd28;
	localparam logic [WORD_W-1:0] TOK_SCALE_BASE = 5'd28;

	typedef logic [DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic done;
		bcd_t digits;
	} conv_res_t;

	typedef enum logic [2:0] {
		PH_HUND,
		PH_HWORD,
		PH_TENS,
		PH_ONES,
		PH_SCALE
	} phase_t;

	typedef enum logic {
		ES_IDLE,
		ES_RUN
	} emit_state_t;

endpackage

FILE: hw/rtl/itw_conv.sv
module itw_conv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [itw_pkg::VALUE_W-1:0]  value,
	output logic                         busy,
	output itw_pkg::conv_res_t           res
);

	logic                             busy_q;
	logic                             done_q;
	logic [itw_pkg::CNT_W-1:0]        cnt_q;
	logic [itw_pkg::VALUE_W-1:0]      bin_q;
	itw_pkg::bcd_t                    bcd_q;
	logic [itw_pkg::DIGITS*4-1:0]     adj;

	// Shift-and-add-three: every digit of five or more is corrected before the shift.
	always_comb begin
		for (int i = 0; i < itw_pkg::DIGITS; i++) begin
			adj[i*4 +: 4] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= itw_pkg::CNT_W'(itw_pkg::VALUE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[itw_pkg::DIGITS*4-2:0], bin_q[itw_pkg::VALUE_W-1]};
		end
	end

	assign busy        = busy_q;
	assign res.done    = done_q;
	assign res.digits  = bcd_q;

endmodule

FILE: hw/rtl/itw_emit.sv
module itw_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  itw_pkg::conv_res_t          conv,
	output logic                        busy,
	output logic                        valid,
	output logic [itw_pkg::WORD_W-1:0]  word,
	output logic                        last
);

	itw_pkg::emit_state_t             state_q, state_d;
	itw_pkg::phase_t                  ph_q, ph_d;
	logic [1:0]                       grp_q, grp_d;
	itw_pkg::bcd_t                    dig_q;
	logic                             pend_v_q, pend_v_d;
	logic [itw_pkg::WORD_W-1:0]       pend_word_q;
	logic                             valid_q, valid_d;
	logic [itw_pkg::WORD_W-1:0]       word_q, word_d;
	logic                             last_q, last_d;
	logic [3:0]                       dh, dt, dn;
	logic                             nz, emit, fin;
	logic [itw_pkg::WORD_W-1:0]       tok;

	always_comb begin
		case (grp_q)
			2'd3: begin
				dh = 4'd0;
				dt = 4'd0;
				dn = dig_q[9];
			end
			2'd2: begin
				dh = dig_q[8];
				dt = dig_q[7];
				dn = dig_q[6];
			end
			2'd1: begin
				dh = dig_q[5];
				dt = dig_q[4];
				dn = dig_q[3];
			end
			default: begin
				dh = dig_q[2];
				dt = dig_q[1];
				dn = dig_q[0];
			end
		endcase
		nz = (dh != 4'd0) || (dt != 4'd0) || (dn != 4'd0);
	end

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		grp_d   = grp_q;
		emit    = 1'b0;
		fin     = 1'b0;
		tok     = itw_pkg::TOK_ZERO;
		case (state_q)
			itw_pkg::ES_IDLE: begin
				if (conv.done) begin
					state_d = itw_pkg::ES_RUN;
					ph_d    = itw_pkg::PH_HUND;
					grp_d   = 2'd3;
				end
			end
			itw_pkg::ES_RUN: begin
				if (!nz) begin
					ph_d = itw_pkg::PH_HUND;
					if (grp_q == 2'd0) begin
						fin = 1'b1;
					end else begin
						grp_d = grp_q - 2'd1;
					end
				end else begin
					case (ph_q)
						itw_pkg::PH_HUND: begin
							if (dh != 4'd0) begin
								emit = 1'b1;
								tok  = itw_pkg::WORD_W'(dh);
								ph_d = itw_pkg::PH_HWORD;
							end else begin
								ph_d = itw_pkg::PH_TENS;
							end
						end
						itw_pkg::PH_HWORD: begin
							emit = 1'b1;
							tok  = itw_pkg::TOK_HUNDRED;
							ph_d = itw_pkg::PH_TENS;
						end
						itw_pkg::PH_TENS: begin
							if (dt >= 4'd2) begin
								emit = 1'b1;
								tok  = itw_pkg::TOK_TENS_BASE + itw_pkg::WORD_W'(dt);
								ph_d = itw_pkg::PH_ONES;
							end else if (dt == 4'd1) begin
								emit = 1'b1;
								tok  = itw_pkg::TOK_TEENS_BASE + itw_pkg::WORD_W'(dn);
								ph_d = itw_pkg::PH_SCALE;
							end else begin
								emit = (dn != 4'd0);
								tok  = itw_pkg::WORD_W'(dn);
								ph_d = itw_pkg::PH_SCALE;
							end
						end
						itw_pkg::PH_ONES: begin
							emit = (dn != 4'd0);
							tok  = itw_pkg::WORD_W'(dn);
							ph_d = itw_pkg::PH_SCALE;
						end
						itw_pkg::PH_SCALE: begin
							ph_d = itw_pkg::PH_HUND;
							if (grp_q == 2'd0) begin
								fin = 1'b1;
							end else begin
								emit  = 1'b1;
								tok   = itw_pkg::TOK_SCALE_BASE + itw_pkg::WORD_W'(grp_q);
								grp_d = grp_q - 2'd1;
							end
						end
						default: begin
							ph_d = itw_pkg::PH_HUND;
						end
					endcase
				end
				if (fin) begin
					state_d = itw_pkg::ES_IDLE;
				end
			end
			default: begin
				state_d = itw_pkg::ES_IDLE;
			end
		endcase
	end

	// A token waits for the next one, so the final one can carry the last mark.
	always_comb begin
		valid_d  = 1'b0;
		word_d   = word_q;
		last_d   = last_q;
		pend_v_d = pend_v_q;
		if (emit) begin
			pend_v_d = 1'b1;
			if (pend_v_q) begin
				valid_d = 1'b1;
				word_d  = pend_word_q;
				last_d  = 1'b0;
			end
		end else if (fin) begin
			pend_v_d = 1'b0;
			valid_d  = 1'b1;
			last_d   = 1'b1;
			word_d   = pend_v_q ? pend_word_q : itw_pkg::TOK_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= itw_pkg::ES_IDLE;
			ph_q     <= itw_pkg::PH_HUND;
			grp_q    <= 2'd0;
			pend_v_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			ph_q     <= ph_d;
			grp_q    <= grp_d;
			pend_v_q <= pend_v_d;
			valid_q  <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
		last_q <= last_d;
		if (emit) begin
			pend_word_q <= tok;
		end
		if (state_q == itw_pkg::ES_IDLE && conv.done) begin
			dig_q <= conv.digits;
		end
	end

	assign busy  = (state_q == itw_pkg::ES_RUN);
	assign valid = valid_q;
	assign word  = word_q;
	assign last  = last_q;

endmodule

FILE: hw/rtl/integer_to_word_tokens.sv
// Spells a non-negative 31-bit integer in English as a run of word tokens.
// Request channel: value is taken at a rising edge with start high and busy
// low. Busy stays high until the last token of that request has been issued.
// Result channel: valid is high for exactly one cycle per token, with word
// holding the token code and last marking the final token of the request.
// The receiver has no way to hold results off, and none is needed.
// The value first passes through a shift-and-add-three decimal converter,
// one bit a cycle, and is then handed over to a sequencer. The sequencer
// walks the four digit groups, the top one a single digit, at up to one
// token a cycle; a zero group, a zero hundreds digit, zero tens and ones
// digits, a zero ones digit after a tens word and the end of the unit group
// each take a sequencer step that yields no new token.
// Asynchronous reset clears the sequencers and the result strobe; the block
// is idle and ready for a request once reset is released.
module integer_to_word_tokens (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [itw_pkg::VALUE_W-1:0] value,
	output logic                        valid,
	output logic [itw_pkg::WORD_W-1:0]  word,
	output logic                        last
);

	`include "integer_to_word_tokens_assert.svh"

	logic               conv_busy;
	logic               emit_busy;
	logic               accept;
	itw_pkg::conv_res_t conv_res;

	assign busy   = conv_busy | conv_res.done | emit_busy;
	assign accept = start & ~busy;

	itw_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.value  (value),
		.busy   (conv_busy),
		.res    (conv_res)
	);

	itw_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.conv   (conv_res),
		.busy   (emit_busy),
		.valid  (valid),
		.word   (word),
		.last   (last)
	);

	`ITW_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`ITW_ASSERT_NEXT(a_last_ends, valid && last, !valid)
	`ITW_ASSERT_IMP(a_mid_busy, valid && !last, busy)
	`ITW_ASSERT_IMP(a_zero_alone, valid && word == itw_pkg::TOK_ZERO, last)

endmodule

FILE: tb/word_token_checker.sv
module word_token_checker
	import itw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [VALUE_W-1:0] value,
	input  logic               valid,
	input  logic [WORD_W-1:0]  word,
	input  logic               last,
	output int                 failures,
	output int                 pending
);

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t word;
		logic  last;
	} token_t;

	localparam word_t TOK_THOUSAND = TOK_SCALE_BASE + word_t'(1);
	localparam word_t TOK_MILLION  = TOK_SCALE_BASE + word_t'(2);
	localparam word_t TOK_BILLION  = TOK_SCALE_BASE + word_t'(3);

	token_t expected_tokens[$];

	function automatic void push_token(input word_t tok);
		token_t t;
		t.word = tok;
		t.last = 1'b0;
		expected_tokens.push_back(t);
	endfunction

	function automatic void spell_group(input int unsigned grp, input word_t scale_tok,
		input bit has_scale);
		int unsigned hund;
		int unsigned rest;
		hund = grp / 100;
		rest = grp % 100;
		if (grp == 0)
			return;
		if (hund != 0) begin
			push_token(word_t'(hund));
			push_token(TOK_HUNDRED);
		end
		if (rest >= 20) begin
			push_token(TOK_TENS_BASE + word_t'(rest / 10));
			if (rest % 10 != 0)
				push_token(word_t'(rest % 10));
		end else if (rest != 0) begin
			push_token(word_t'(rest));
		end
		if (has_scale)
			push_token(scale_tok);
	endfunction

	function automatic void spell_value(input logic [VALUE_W-1:0] v);
		int unsigned n;
		n = int'(v);
		if (n == 0) begin
			push_token(TOK_ZERO);
		end else begin
			spell_group(n / 1000000000, TOK_BILLION, 1'b1);
			n = n % 1000000000;
			spell_group(n / 1000000, TOK_MILLION, 1'b1);
			n = n % 1000000;
			spell_group(n / 1000, TOK_THOUSAND, 1'b1);
			spell_group(n % 1000, TOK_ZERO, 1'b0);
		end
		expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		token_t exp_tok;
		if (arst_n) begin
			if (start && !busy)
				spell_value(value);
			if (valid) begin
				if (expected_tokens.size() == 0) begin
					failures++;
					$error("unexpected token: word %0d, last %0d", word, last);
				end else begin
					exp_tok = expected_tokens.pop_front();
					if (word !== exp_tok.word) begin
						failures++;
						$error("word: expected %0d, actual %0d", exp_tok.word, word);
					end
					if (last !== exp_tok.last) begin
						failures++;
						$error("last: expected %0d, actual %0d", exp_tok.last, last);
					end
				end
			end
			pending = expected_tokens.size();
		end
	end

endmodule

FILE: tb/integer_to_word_tokens_tb.sv
module integer_to_word_tokens_tb;
	import itw_pkg::*;

	localparam int RANDOM_ITEMS = 320;
	localparam int TAIL_CYCLES  = 80;
	localparam int DRAIN_LIMIT  = 5000;

	localparam int unsigned DIRECTED [24] = '{
		0, 1, 9, 10, 11, 15, 19, 20, 21, 99, 100, 101, 110, 999, 1000, 1001,
		20000, 1010010, 1000000, 1000000000, 2000000000, 1234567890, 1777777777,
		2147483647
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value;
	logic               valid;
	logic [WORD_W-1:0]  word;
	logic               last;
	int                 failures;
	int                 pending;

	integer_to_word_tokens i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.value  (value),
		.valid  (valid),
		.word   (word),
		.last   (last)
	);

	word_token_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.valid    (valid),
		.word     (word),
		.last     (last),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

	// A gap of zero keeps start high, so back-to-back requests follow at once.
	task automatic issue_request(input logic [VALUE_W-1:0] v, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	function automatic int unsigned pick_group();
		int unsigned grp;
		case ($urandom_range(0, 5))
			0: grp = 0;
			1: grp = $urandom_range(1, 9);
			2: grp = $urandom_range(10, 19);
			3: grp = $urandom_range(1, 9) * 100 + $urandom_range(10, 19);
			4: grp = $urandom_range(1, 9) * 100 + $urandom_range(2, 9) * 10
				+ $urandom_range(1, 9);
			default: grp = $urandom_range(0, 999);
		endcase
		return grp;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		longint total;
		case ($urandom_range(0, 9))
			0, 1, 2: total = longint'($urandom() & 32'h7FFF_FFFF);
			3: total = $urandom_range(0, 999);
			default: begin
				total = longint'($urandom_range(0, 2)) * 1000000000
					+ longint'(pick_group()) * 1000000
					+ longint'(pick_group()) * 1000
					+ longint'(pick_group());
				if (total > 64'd2147483647)
					total = total - 1000000000;
			end
		endcase
		return VALUE_W'(total);
	endfunction

	initial begin
		bit burst;
		int gap;
		int waited;
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		burst  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			issue_request(VALUE_W'(DIRECTED[i]), $urandom_range(0, 3));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 16 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 14);
			issue_request(pick_value(), gap);
		end
		start <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending != 0)
			$error("%0d expected tokens never arrived", pending);
		if (failures == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
